FILE: src/pwm_pkg.sv
// Shared constants, types and the character folding function of the phonetic word matcher.
package pwm_pkg;

  localparam int MaxWordLen = 16;
  localparam int CharW      = 8;
  localparam int CountW     = $clog2(MaxWordLen + 1);
  localparam int IdxW       = $clog2(MaxWordLen);
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int PatW       = 2 * CfgDataW;

  localparam logic [CfgIdxW-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAT_LEN  = 2'd2;

  localparam logic [CharW-1:0] SpaceChar   = 8'h20;
  localparam logic [CharW-1:0] UpperFirst  = 8'h41;
  localparam logic [CharW-1:0] UpperLast   = 8'h5A;
  localparam logic [CharW-1:0] CaseOffset  = 8'h20;
  localparam logic [CountW-1:0] PatLenReset = 5'd1;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  addr;
    logic [CharW-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] last_idx;
    logic            miss;
  } word_evt_t;

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    logic [CharW-1:0] res;
    lc = (c >= UpperFirst && c <= UpperLast) ? c + CaseOffset : c;
    case (lc)
      "w":      res = "v";
      "f", "p": res = "b";
      "j":      res = "g";
      "k", "q": res = "c";
      "z":      res = "s";
      "t":      res = "d";
      "u":      res = "o";
      "y":      res = "i";
      default:  res = lc;
    endcase
    return res;
  endfunction

endpackage

FILE: src/pwm_cfg_regs.sv
// Configuration registers holding the search word and its length.
module pwm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [pwm_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [pwm_pkg::CfgDataW-1:0]  wr_data,
  output logic [pwm_pkg::PatW-1:0]      pat_chars,
  output logic [pwm_pkg::CountW-1:0]    pat_len
);
  import pwm_pkg::*;

  logic [CfgDataW-1:0] pat_low_r;
  logic [CfgDataW-1:0] pat_high_r;
  logic [CountW-1:0]   pat_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= PatLenReset;
    end else if (wr_en) begin
      case (wr_index)
        CFG_PAT_LOW:  pat_low_r  <= wr_data;
        CFG_PAT_HIGH: pat_high_r <= wr_data;
        CFG_PAT_LEN:  pat_len_r  <= wr_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign pat_chars = {pat_high_r, pat_low_r};
  assign pat_len   = pat_len_r;

endmodule

FILE: src/pwm_word_tracker.sv
// Word tracker: splits the byte stream into words and compares each character as it arrives.
module pwm_word_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [pwm_pkg::CharW-1:0]   char_in,
  input  logic                        end_in,
  input  logic [pwm_pkg::PatW-1:0]    pat_chars,
  input  logic [pwm_pkg::CountW-1:0]  pat_len,
  output pwm_pkg::buf_wr_t            wr,
  output pwm_pkg::word_evt_t          evt
);
  import pwm_pkg::*;

  logic [CountW-1:0] count_r, count_nxt;
  logic              still_r, still_nxt;
  logic              long_r, long_nxt;
  logic              found_r, found_nxt;
  logic              is_space;
  logic              hit;
  logic [CountW-1:0] len_m1;
  logic [CharW-1:0]  pat_ch;
  logic [IdxW-1:0]   pos;

  assign pos      = count_r[IdxW-1:0];
  assign pat_ch   = pat_chars[{pos, 3'b000} +: CharW];
  assign is_space = (char_in == SpaceChar);

  always_comb begin
    count_nxt = count_r;
    still_nxt = still_r;
    long_nxt  = long_r;
    found_nxt = found_r;
    wr        = '0;
    evt       = '0;
    hit       = 1'b0;
    len_m1    = '0;
    if (accept) begin
      if (!found_r) begin
        if (!is_space) begin
          if (count_r < CountW'(MaxWordLen)) begin
            if (count_r >= pat_len || fold_char(char_in) != fold_char(pat_ch)) begin
              still_nxt = 1'b0;
            end
            wr.we     = 1'b1;
            wr.addr   = pos;
            wr.data   = char_in;
            count_nxt = count_r + CountW'(1);
          end else begin
            long_nxt = 1'b1;
          end
        end
        if (is_space || end_in) begin
          hit = !long_nxt && still_nxt && (count_nxt != '0) && (count_nxt == pat_len);
          len_m1       = count_nxt - CountW'(1);
          evt.hit      = hit;
          evt.last_idx = len_m1[IdxW-1:0];
          found_nxt    = hit;
          count_nxt    = '0;
          still_nxt    = 1'b1;
          long_nxt     = 1'b0;
        end
        evt.miss = end_in && !hit;
      end
      if (end_in) begin
        count_nxt = '0;
        still_nxt = 1'b1;
        long_nxt  = 1'b0;
        found_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      still_r <= 1'b1;
      long_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      still_r <= still_nxt;
      long_r  <= long_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

FILE: src/pwm_emitter.sv
// Result emitter: word buffer, run counter and the output register.
module pwm_emitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pwm_pkg::buf_wr_t           wr,
  input  pwm_pkg::word_evt_t         evt,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [pwm_pkg::CharW-1:0]  out_char,
  output logic                       out_outcome,
  output logic                       out_last,
  output logic                       item_ready
);
  import pwm_pkg::*;

  logic [CharW-1:0] word_q [MaxWordLen];

  logic             out_valid_r, out_valid_nxt;
  logic [CharW-1:0] char_r, char_nxt;
  logic             outcome_r, outcome_nxt;
  logic             last_r, last_nxt;
  logic             active_r, active_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [IdxW-1:0]  last_idx_r, last_idx_nxt;
  logic             out_free;
  logic             run_end;

  assign out_free   = !out_valid_r || out_ready;
  assign run_end    = (idx_r == last_idx_r);
  assign item_ready = !active_r && out_free;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      word_q[wr.addr] <= wr.data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    outcome_nxt   = outcome_r;
    last_nxt      = last_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (active_r && out_free) begin
      out_valid_nxt = 1'b1;
      char_nxt      = word_q[idx_r];
      outcome_nxt   = 1'b0;
      last_nxt      = run_end;
      if (run_end) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IdxW'(1);
      end
    end
    if (evt.miss) begin
      out_valid_nxt = 1'b1;
      char_nxt      = '0;
      outcome_nxt   = 1'b1;
      last_nxt      = 1'b1;
    end
    if (evt.hit) begin
      active_nxt   = 1'b1;
      idx_nxt      = '0;
      last_idx_nxt = evt.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    outcome_r  <= outcome_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_char    = char_r;
  assign out_outcome = outcome_r;
  assign out_last    = last_r;

endmodule

FILE: src/phonetic_word_matcher.sv
// Phonetic word matcher top level: takes one sentence byte per cycle while in_ready is high and
// reports the first match. A not-found result is in the output register in the cycle after the
// final byte is taken. A matched word streams out one byte per cycle while out_ready is high,
// once its closing byte has set active_r; input is held off while the run is sent.
// Otherwise one byte is taken every cycle, paced only by out_ready on the output register.
// Synchronous active-low reset clears word state, the pattern (length 1) and the output valid.
module phonetic_word_matcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pwm_pkg::CharW-1:0]     in_sentence_char,
  input  logic                          in_sentence_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pwm_pkg::CharW-1:0]     out_found_char,
  output logic                          out_outcome,
  output logic                          out_run_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pwm_pkg::CfgDataW-1:0]  cfg_data
);
  import pwm_pkg::*;

  logic             accept;
  logic [PatW-1:0]  pat_chars;
  logic [CountW-1:0] pat_len;
  buf_wr_t          wr;
  word_evt_t        evt;
  logic             item_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = item_ready;
  assign accept    = in_valid && item_ready;

  pwm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .pat_chars (pat_chars),
    .pat_len   (pat_len)
  );

  pwm_word_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_in   (in_sentence_char),
    .end_in    (in_sentence_end),
    .pat_chars (pat_chars),
    .pat_len   (pat_len),
    .wr        (wr),
    .evt       (evt)
  );

  pwm_emitter u_emitter (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .evt         (evt),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_char    (out_found_char),
    .out_outcome (out_outcome),
    .out_last    (out_run_last),
    .item_ready  (item_ready)
  );

endmodule
